@@ hdl/pmfa_pkg.sv @@
// Shared types, constants and helpers for the physical memory with frame allocator.
// Depends on nothing; every other file of the block refers to it by scoped names.
package pmfa_pkg;

  localparam int unsigned MEM_BYTES   = 65536;
  localparam int unsigned PAGE_BYTES  = 256;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned STORE_DEPTH = 2 ** ADDR_W;
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned FRAME_W     = 8;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned CMP_W       = 26;

  localparam int unsigned FRAMES_RAW  = MEM_BYTES / PAGE_BYTES;
  localparam int unsigned NUM_FRAMES  =
    (FRAMES_RAW > STACK_DEPTH) ? STACK_DEPTH : FRAMES_RAW;
  localparam logic [COUNT_W-1:0] NUM_FRAMES_C = COUNT_W'(NUM_FRAMES);
  localparam logic [CMP_W-1:0]   MEM_BYTES_C  = CMP_W'(MEM_BYTES);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_TAKE   = 2'd2,
    OP_RETURN = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FRAME  = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_LIST_FULL = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_BUSY = 1'b1
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic exec;      // perform the accepted word's memory and stack operation
    logic load_out;  // capture the finished result into the output register
  } cmd_t;

  // Frame held by a stack entry that has not been written since reset
  function automatic logic [FRAME_W-1:0] reset_frame(input logic [FRAME_W-1:0] idx);
    logic [COUNT_W-1:0] wide_idx;
    logic [COUNT_W-1:0] diff;
    wide_idx = COUNT_W'(idx);
    diff     = NUM_FRAMES_C - wide_idx - COUNT_W'(1);
    if (wide_idx < NUM_FRAMES_C) begin
      return diff[FRAME_W-1:0];
    end
    return '0;
  endfunction

endpackage

@@ hdl/pmfa_ctrl.sv @@
// Controller of the frame allocator: accepts one word at a time and hands the
// result to the output register. Depends on pmfa_pkg.
module pmfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output pmfa_pkg::cmd_t  cmd
);

  pmfa_pkg::state_t state;
  pmfa_pkg::state_t state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pmfa_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    unique case (state)
      pmfa_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.exec   = 1'b1;
          state_next = pmfa_pkg::S_BUSY;
        end
      end
      pmfa_pkg::S_BUSY: begin
        // hold the result until the output register frees up
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = pmfa_pkg::S_IDLE;
        end
      end
      default: state_next = pmfa_pkg::S_IDLE;
    endcase
    out_valid_next = cmd.load_out || (out_valid && out_stall);
  end

  a_exec_load_apart: assert property (@(posedge clk) disable iff (rst)
    !(cmd.exec && cmd.load_out))
    else $error("exec and load_out asserted together");

  a_exec_then_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> (state == pmfa_pkg::S_BUSY && in_stall))
    else $error("controller took no busy cycle after exec");

  a_load_gives_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.load_out)
    else $error("stalled result overwritten");

endmodule

@@ hdl/pmfa_datapath.sv @@
// Datapath of the frame allocator: byte store, free-frame stack with valid
// bits, free count and the output register. Depends on pmfa_pkg.
module pmfa_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  pmfa_pkg::cmd_t                 cmd,
  input  logic [1:0]                     opcode,
  input  logic [pmfa_pkg::ADDR_W-1:0]    address,
  input  logic [7:0]                     write_data,
  input  logic [pmfa_pkg::FRAME_W-1:0]   frame_number,
  output logic [7:0]                     read_data,
  output logic [pmfa_pkg::FRAME_W-1:0]   frame_out,
  output logic [1:0]                     status
);

  logic [7:0]                    byte_store [pmfa_pkg::STORE_DEPTH];
  logic [pmfa_pkg::FRAME_W-1:0]  free_stack [pmfa_pkg::STACK_DEPTH];
  logic [pmfa_pkg::STACK_DEPTH-1:0] stack_valid;
  logic [pmfa_pkg::COUNT_W-1:0]  free_count;

  pmfa_pkg::opcode_t             op;
  logic                          addr_ok;
  logic                          stack_empty;
  logic                          stack_full;
  logic [pmfa_pkg::COUNT_W-1:0]  count_dec;
  logic [pmfa_pkg::FRAME_W-1:0]  pop_idx;
  logic [pmfa_pkg::FRAME_W-1:0]  push_idx;
  logic                          do_write;
  logic                          do_pop;
  logic                          do_push;

  // registered operation context, held between exec and load_out
  pmfa_pkg::opcode_t             op_q;
  logic                          addr_bad_q;
  logic                          empty_q;
  logic                          full_q;
  logic [7:0]                    byte_rd;
  logic [pmfa_pkg::FRAME_W-1:0]  stack_rd;
  logic                          stack_rd_valid;
  logic [pmfa_pkg::FRAME_W-1:0]  pop_idx_q;

  logic [7:0]                    read_data_next;
  logic [pmfa_pkg::FRAME_W-1:0]  frame_out_next;
  pmfa_pkg::status_t             status_next;

  always_comb begin
    op          = pmfa_pkg::opcode_t'(opcode);
    addr_ok     = pmfa_pkg::CMP_W'(address) < pmfa_pkg::MEM_BYTES_C;
    stack_empty = (free_count == '0);
    stack_full  = free_count[pmfa_pkg::COUNT_W-1];
    count_dec   = free_count - pmfa_pkg::COUNT_W'(1);
    pop_idx     = count_dec[pmfa_pkg::FRAME_W-1:0];
    push_idx    = free_count[pmfa_pkg::FRAME_W-1:0];
    do_write    = cmd.exec && (op == pmfa_pkg::OP_WRITE) && addr_ok;
    do_pop      = cmd.exec && (op == pmfa_pkg::OP_TAKE) && !stack_empty;
    do_push     = cmd.exec && (op == pmfa_pkg::OP_RETURN) && !stack_full;
  end

  // byte store: at most one write and one registered read per word
  always_ff @(posedge clk) begin
    if (do_write) begin
      byte_store[address] <= write_data;
    end
    if (cmd.exec) begin
      byte_rd <= byte_store[address];
    end
  end

  // free stack array: push writes at the count, pop reads just below it
  always_ff @(posedge clk) begin
    if (do_push) begin
      free_stack[push_idx] <= frame_number;
    end
    if (do_pop) begin
      stack_rd <= free_stack[pop_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stack_valid <= '0;
      free_count  <= pmfa_pkg::NUM_FRAMES_C;
    end else begin
      if (do_push) begin
        stack_valid[push_idx] <= 1'b1;
        free_count            <= free_count + pmfa_pkg::COUNT_W'(1);
      end else if (do_pop) begin
        free_count            <= count_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      op_q           <= op;
      addr_bad_q     <= !addr_ok;
      empty_q        <= stack_empty;
      full_q         <= stack_full;
      stack_rd_valid <= stack_valid[pop_idx];
      pop_idx_q      <= pop_idx;
    end
  end

  always_comb begin
    read_data_next = '0;
    frame_out_next = '0;
    status_next    = pmfa_pkg::ST_OK;
    unique case (op_q)
      pmfa_pkg::OP_READ: begin
        if (addr_bad_q) begin
          status_next = pmfa_pkg::ST_BAD_ADDR;
        end else begin
          read_data_next = byte_rd;
        end
      end
      pmfa_pkg::OP_WRITE: begin
        if (addr_bad_q) begin
          status_next = pmfa_pkg::ST_BAD_ADDR;
        end
      end
      pmfa_pkg::OP_TAKE: begin
        if (empty_q) begin
          status_next = pmfa_pkg::ST_NO_FRAME;
        end else if (stack_rd_valid) begin
          frame_out_next = stack_rd;
        end else begin
          frame_out_next = pmfa_pkg::reset_frame(pop_idx_q);
        end
      end
      pmfa_pkg::OP_RETURN: begin
        if (full_q) begin
          status_next = pmfa_pkg::ST_LIST_FULL;
        end
      end
      default: status_next = pmfa_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data <= read_data_next;
      frame_out <= frame_out_next;
      status    <= status_next;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    free_count <= pmfa_pkg::COUNT_W'(pmfa_pkg::STACK_DEPTH))
    else $error("free count beyond stack depth");

endmodule

@@ hdl/phys_memory_with_frame_allocator.sv @@
// Top level of the physical byte memory with LIFO free-frame allocator.
// Depends on pmfa_pkg, pmfa_ctrl and pmfa_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word: opcode, address,
//   write_data and frame_number. Opcodes: read byte, write byte, take the
//   top free frame, return a frame to the free stack.
//   Output channel (out_valid / out_stall) carries one result word per input
//   word: read_data, frame_out and status (ok, no free frame, bad address,
//   free list full).
// Timing:
//   A word is taken in the idle state; the byte store and the stack are
//   accessed on that same edge. In the busy state the result is loaded into
//   the output register as soon as that register is free, and only then does
//   the block go idle and take the next word; this pace is set by the
//   registered read port of the byte store and of the stack.
//   While the previous result is still stalled, the finished result waits
//   in the datapath and in_stall stays high; nothing is dropped.
// Reset:
//   rst clears the controller, marks every stack entry unwritten (reading
//   as its formatted frame, so takes give frames 0, 1, 2, ... in order) and
//   sets the free count to the number of frames. The byte store is not
//   cleared; a byte must be written before it is read.
module phys_memory_with_frame_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    opcode,
  input  logic [pmfa_pkg::ADDR_W-1:0]   address,
  input  logic [7:0]                    write_data,
  input  logic [pmfa_pkg::FRAME_W-1:0]  frame_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    read_data,
  output logic [pmfa_pkg::FRAME_W-1:0]  frame_out,
  output logic [1:0]                    status
);

  // command bundle from the controller to the datapath
  pmfa_pkg::cmd_t cmd;

  // sequence the handshake: accept, execute, present
  pmfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // store bytes, keep the free stack, build and hold the result word
  pmfa_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .opcode       (opcode),
    .address      (address),
    .write_data   (write_data),
    .frame_number (frame_number),
    .read_data    (read_data),
    .frame_out    (frame_out),
    .status       (status)
  );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for phys_memory_with_frame_allocator: byte reads and writes,
// frame takes and returns, checked word by word against an in-bench scoreboard.
// Depends on pmfa_pkg and the block's RTL only.
module tb_top;
  import pmfa_pkg::*;

  localparam int N_RANDOM   = 1534;
  localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN_WAIT = 20;    // extra cycles after the drain to catch stray words

  typedef struct {
    logic [7:0]         rd;
    logic [FRAME_W-1:0] fo;
    status_t            st;
  } result_t;

  // Scoreboard: keeps its own image of the byte store and the free-frame stack,
  // works out the result for every accepted input word and checks output words
  // against those results in order.
  class pmfa_scoreboard;
    logic [7:0]         byte_image [STORE_DEPTH];
    bit                 written [STORE_DEPTH];
    int unsigned        written_addrs [$];
    logic [FRAME_W-1:0] frame_stack [STACK_DEPTH];
    int                 free_count;
    result_t            pending_results [$];
    int                 failures;
    int                 reported;

    function new();
      for (int i = 0; i < STACK_DEPTH; i++) begin
        frame_stack[i] = (i < NUM_FRAMES) ? FRAME_W'(NUM_FRAMES - 1 - i) : '0;
      end
      free_count = NUM_FRAMES;
      failures   = 0;
      reported   = 0;
    endfunction

    // Apply one accepted word to the image and queue the result it must give.
    function void note_word(opcode_t op, logic [ADDR_W-1:0] addr, logic [7:0] wdata,
                            logic [FRAME_W-1:0] fnum);
      result_t res;
      res.rd = '0;
      res.fo = '0;
      res.st = ST_OK;
      case (op)
        OP_READ: begin
          if (addr < MEM_BYTES) res.rd = byte_image[addr];
          else res.st = ST_BAD_ADDR;
        end
        OP_WRITE: begin
          if (addr < MEM_BYTES) begin
            byte_image[addr] = wdata;
            if (!written[addr]) begin
              written[addr] = 1'b1;
              written_addrs.push_back(addr);
            end
          end else begin
            res.st = ST_BAD_ADDR;
          end
        end
        OP_TAKE: begin
          if (free_count == 0) begin
            res.st = ST_NO_FRAME;
          end else begin
            free_count--;
            res.fo = frame_stack[free_count];
          end
        end
        default: begin
          if (free_count >= STACK_DEPTH) begin
            res.st = ST_LIST_FULL;
          end else begin
            frame_stack[free_count] = fnum;
            free_count++;
          end
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void check_result(logic [7:0] rd, logic [FRAME_W-1:0] fo, logic [1:0] st);
      result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] unexpected result word: rd=%02h fo=%02h st=%0d", $realtime, rd, fo, st);
        end
        return;
      end
      want = pending_results.pop_front();
      if (rd !== want.rd || fo !== want.fo || st !== want.st) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("[%0t] mismatch: expected rd=%02h fo=%02h st=%s, got rd=%02h fo=%02h st=%0d",
                   $realtime, want.rd, want.fo, want.st.name(), rd, fo, st);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           opcode;
  logic [ADDR_W-1:0]    address;
  logic [7:0]           write_data;
  logic [FRAME_W-1:0]   frame_number;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [7:0]           read_data;
  logic [FRAME_W-1:0]   frame_out;
  logic [1:0]           status;

  pmfa_scoreboard board;
  int  calm_in;        // words still to send back to back
  int  stall_left;     // cycles of the current output stall still to hold
  int  calm_out;       // cycles still to run with the output open
  int  pick;
  int  idle_cycles;
  bit  drain_dir;      // random part: 1 walks the stack down, 0 fills it back up

  phys_memory_with_frame_allocator i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .address      (address),
    .write_data   (write_data),
    .frame_number (frame_number),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_data    (read_data),
    .frame_out    (frame_out),
    .status       (status)
  );

  always #5 clk = ~clk;

  // Gap before the next input word: mostly none, often short, now and then long,
  // with occasional runs of back-to-back words.
  function automatic int pick_in_gap();
    int r;
    r = $urandom_range(99);
    if (calm_in > 0) begin
      calm_in--;
      return 0;
    end
    if (r < 5) begin
      calm_in = $urandom_range(80, 20);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Present one word and hold it until the block takes it. Valid is only
  // dropped when a gap is wanted, so it is never lowered and raised in one step.
  task automatic send_word(input opcode_t op, input logic [ADDR_W-1:0] addr,
                           input logic [7:0] wdata, input logic [FRAME_W-1:0] fnum);
    int gap;
    gap = pick_in_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    address      <= addr;
    write_data   <= wdata;
    frame_number <= fnum;
    do @(posedge clk); while (in_stall);
    board.note_word(op, addr, wdata, fnum);
  endtask

  // Stack operation with random padding in the unused fields.
  task automatic send_stack_op(input opcode_t op, input logic [FRAME_W-1:0] fnum);
    send_word(op, ADDR_W'($urandom), 8'($urandom), fnum);
  endtask

  // One random word. Memory traffic reads only bytes already written; stack
  // traffic drifts towards empty or full so both ends are hit repeatedly.
  task automatic send_random_word();
    int r;
    int unsigned addr;
    opcode_t op;
    r = $urandom_range(99);
    if (r < 40) begin
      if (board.written_addrs.size() == 0 || $urandom_range(1) == 0) begin
        if (board.written_addrs.size() != 0 && $urandom_range(3) == 0)
          addr = board.written_addrs[$urandom_range(board.written_addrs.size() - 1)];
        else
          addr = $urandom_range(STORE_DEPTH - 1);
        send_word(OP_WRITE, ADDR_W'(addr), 8'($urandom), FRAME_W'($urandom));
      end else begin
        addr = board.written_addrs[$urandom_range(board.written_addrs.size() - 1)];
        send_word(OP_READ, ADDR_W'(addr), 8'($urandom), FRAME_W'($urandom));
      end
    end else begin
      // At an end of the stack, turn round now and then; until then keep
      // pushing against it so empty takes and full returns turn up.
      if ((drain_dir && board.free_count == 0) ||
          (!drain_dir && board.free_count >= STACK_DEPTH)) begin
        if ($urandom_range(99) < 35) drain_dir = !drain_dir;
      end
      if ($urandom_range(99) < 85) op = drain_dir ? OP_TAKE : OP_RETURN;
      else op = drain_dir ? OP_RETURN : OP_TAKE;
      send_stack_op(op, FRAME_W'($urandom));
    end
  endtask

  // Output stall: short and long stalls, single open cycles, and open stretches.
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      calm_out   <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (calm_out > 0) begin
      out_stall <= 1'b0;
      calm_out  <= calm_out - 1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        out_stall <= 1'b0;
        calm_out  <= $urandom_range(150, 30);
      end else if (pick < 55) begin
        out_stall <= 1'b0;
      end else if (pick < 92) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(2, 0);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(39, 9);
      end
    end
  end

  // Check every output word taken at this edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(read_data, frame_out, status);
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    board        = new();
    calm_in      = 0;
    drain_dir    = 1'b1;
    rst          = 1'b1;
    in_valid     = 1'b0;
    opcode       = OP_READ;
    address      = '0;
    write_data   = '0;
    frame_number = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: address and data extremes, read back of written bytes.
    send_word(OP_WRITE, '0, 8'h00, 8'h00);
    send_word(OP_WRITE, '1, 8'hFF, 8'hFF);
    send_word(OP_WRITE, 16'h5AA5, 8'hA5, 8'h5A);
    send_word(OP_READ, '1, 8'h00, 8'h00);
    send_word(OP_READ, '0, 8'hFF, 8'hFF);
    send_word(OP_READ, 16'h5AA5, 8'h00, 8'h00);
    send_word(OP_WRITE, 16'h5AA5, 8'h3C, 8'h00);
    send_word(OP_READ, 16'h5AA5, 8'h00, 8'h00);
    // Return while every frame is free: list full, frame dropped.
    send_stack_op(OP_RETURN, 8'hFF);
    send_stack_op(OP_RETURN, 8'h00);
    // Takes come out in order from frame 0.
    send_stack_op(OP_TAKE, 8'h00);
    send_stack_op(OP_TAKE, 8'hFF);
    // Returns take any value, also one that is already free.
    send_stack_op(OP_RETURN, 8'hFF);
    send_stack_op(OP_RETURN, 8'h00);
    send_stack_op(OP_RETURN, 8'h80);
    send_stack_op(OP_TAKE, 8'h00);
    send_stack_op(OP_TAKE, 8'h00);
    send_stack_op(OP_TAKE, 8'h00);
    send_stack_op(OP_TAKE, 8'h00);

    // Random part; the empty stack is reached through the drift.
    for (int n = 0; n < N_RANDOM; n++) send_random_word();
    in_valid <= 1'b0;

    // Drain: wait for every expected word, then a little longer to catch strays.
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (board.failures == 0 && board.pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
